// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/rfc_pkg.sv -----
package rfc_pkg;

   localparam int DEPTH      = 16;
   localparam int ELEM_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int DATA_W     = 32;
   localparam int STAT_W     = 32;
   localparam int OCC_W      = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic clear;
      logic enq_ok;
      logic enq_full;
      logic deq_ok;
      logic deq_empty;
   } stat_evt_type;

   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] res;
      if (cap == '0) begin
         res = CNT_W'(1);
      end else if (int'(cap) > DEPTH) begin
         res = CNT_W'(DEPTH);
      end else begin
         res = CNT_W'(cap);
      end
      return res;
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] nx;
      nx = (CNT_W+1)'(ptr) + (CNT_W+1)'(1);
      return (nx >= (CNT_W+1)'(cap)) ? '0 : PTR_W'(nx);
   endfunction

endpackage

// ----- sv/ring_fifo_with_counters.sv -----
// Ring FIFO with four saturating statistics counters. Each item is an enqueue
// (op 0, stores data_in) or a dequeue (op 1, returns the oldest element), and
// each item yields exactly one result carrying status, the dequeued data, the
// empty and full flags, the occupancy and the counters as they stand after
// that item. The storage is a synchronous RAM with a registered read port; a
// result is loaded once the read is done and the output register is free; no
// item is taken before that. A finished result waits in an output register
// while the next item is already taken. Writing the capacity register (0 acts
// as 1, values above the depth act as the depth) empties the queue and clears
// all counters; it must only be written while the block is idle.
module ring_fifo_with_counters (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rfc_pkg::CAP_W-1:0]     csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [rfc_pkg::DATA_W-1:0]    req_data_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [rfc_pkg::DATA_W-1:0]    rsp_data_out,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,
   output logic [rfc_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic [rfc_pkg::STAT_W-1:0]    rsp_enqueue_count,
   output logic [rfc_pkg::STAT_W-1:0]    rsp_enqueue_full_count,
   output logic [rfc_pkg::STAT_W-1:0]    rsp_dequeue_count,
   output logic [rfc_pkg::STAT_W-1:0]    rsp_dequeue_empty_count
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DONE = 2'b10
   } state_type;

   state_type                       state_ff, state_in;
   logic [rfc_pkg::CAP_W-1:0]       cap_ff;
   logic [rfc_pkg::PTR_W-1:0]       wptr_ff, wptr_in;
   logic [rfc_pkg::PTR_W-1:0]       rptr_ff, rptr_in;
   logic [rfc_pkg::CNT_W-1:0]       fill_ff, fill_in;
   logic                            status_ff;
   logic                            took_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_status_ff;
   logic [rfc_pkg::DATA_W-1:0]      rsp_data_ff;
   logic                            rsp_empty_ff;
   logic                            rsp_full_ff;
   logic [rfc_pkg::OCC_W-1:0]       rsp_occ_ff;
   logic [rfc_pkg::STAT_W-1:0]      rsp_enq_ff, rsp_enq_full_ff;
   logic [rfc_pkg::STAT_W-1:0]      rsp_deq_ff, rsp_deq_empty_ff;

   logic [rfc_pkg::CNT_W-1:0]       cap_eff;
   logic                            accept;
   logic                            load;
   rfc_pkg::stat_evt_type           evt;
   logic [rfc_pkg::ELEM_WIDTH-1:0]  rd_data;
   logic [rfc_pkg::STAT_W-1:0]      enq_cnt, enq_full_cnt, deq_cnt, deq_empty_cnt;

   assign cap_eff   = rfc_pkg::eff_cap(cap_ff);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      evt.clear     = csr_wr_en;
      evt.enq_ok    = accept && (req_op == rfc_pkg::OP_ENQ) && (fill_ff < cap_eff);
      evt.enq_full  = accept && (req_op == rfc_pkg::OP_ENQ) && !(fill_ff < cap_eff);
      evt.deq_ok    = accept && (req_op == rfc_pkg::OP_DEQ) && (fill_ff != '0);
      evt.deq_empty = accept && (req_op == rfc_pkg::OP_DEQ) && (fill_ff == '0);
   end

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (evt.enq_ok) begin
         wptr_in = rfc_pkg::next_ptr(wptr_ff, cap_eff);
         fill_in = fill_ff + rfc_pkg::CNT_W'(1);
      end
      if (evt.deq_ok) begin
         rptr_in = rfc_pkg::next_ptr(rptr_ff, cap_eff);
         fill_in = fill_ff - rfc_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= rfc_pkg::CAP_RESET;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff  <= csr_wr_data;
            wptr_ff <= '0;
            rptr_ff <= '0;
            fill_ff <= '0;
         end else begin
            wptr_ff <= wptr_in;
            rptr_ff <= rptr_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= (evt.enq_full || evt.deq_empty) ? rfc_pkg::STATUS_REJECT
                                                      : rfc_pkg::STATUS_DONE;
         took_ff   <= evt.deq_ok;
      end
      if (load) begin
         rsp_status_ff    <= status_ff;
         rsp_data_ff      <= took_ff ? rfc_pkg::DATA_W'(rd_data) : '0;
         rsp_empty_ff     <= (fill_ff == '0);
         rsp_full_ff      <= (fill_ff == cap_eff);
         rsp_occ_ff       <= rfc_pkg::OCC_W'(fill_ff);
         rsp_enq_ff       <= enq_cnt;
         rsp_enq_full_ff  <= enq_full_cnt;
         rsp_deq_ff       <= deq_cnt;
         rsp_deq_empty_ff <= deq_empty_cnt;
      end
   end

   rfc_ram #(
      .WIDTH  (rfc_pkg::ELEM_WIDTH),
      .DEPTH  (rfc_pkg::DEPTH),
      .ADDR_W (rfc_pkg::PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (evt.enq_ok),
      .wr_addr (wptr_ff),
      .wr_data (req_data_in[rfc_pkg::ELEM_WIDTH-1:0]),
      .rd_en   (evt.deq_ok),
      .rd_addr (rptr_ff),
      .rd_data (rd_data)
   );

   rfc_stats u_stats (
      .clock         (clock),
      .reset         (reset),
      .evt           (evt),
      .enq_ok_cnt    (enq_cnt),
      .enq_full_cnt  (enq_full_cnt),
      .deq_ok_cnt    (deq_cnt),
      .deq_empty_cnt (deq_empty_cnt)
   );

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_data_out            = rsp_data_ff;
   assign rsp_is_empty            = rsp_empty_ff;
   assign rsp_is_full             = rsp_full_ff;
   assign rsp_occupancy           = rsp_occ_ff;
   assign rsp_enqueue_count       = rsp_enq_ff;
   assign rsp_enqueue_full_count  = rsp_enq_full_ff;
   assign rsp_dequeue_count       = rsp_deq_ff;
   assign rsp_dequeue_empty_count = rsp_deq_empty_ff;

endmodule

// ----- sv/rfc_ram.sv -----
module rfc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rfc_stats.sv -----
module rfc_stats (
   input  logic                         clock,
   input  logic                         reset,
   input  rfc_pkg::stat_evt_type        evt,
   output logic [rfc_pkg::STAT_W-1:0]   enq_ok_cnt,
   output logic [rfc_pkg::STAT_W-1:0]   enq_full_cnt,
   output logic [rfc_pkg::STAT_W-1:0]   deq_ok_cnt,
   output logic [rfc_pkg::STAT_W-1:0]   deq_empty_cnt
);

   logic [rfc_pkg::STAT_W-1:0] enq_ok_ff, enq_ok_in;
   logic [rfc_pkg::STAT_W-1:0] enq_full_ff, enq_full_in;
   logic [rfc_pkg::STAT_W-1:0] deq_ok_ff, deq_ok_in;
   logic [rfc_pkg::STAT_W-1:0] deq_empty_ff, deq_empty_in;

   function automatic logic [rfc_pkg::STAT_W-1:0] sat_inc(
      input logic [rfc_pkg::STAT_W-1:0] v, input logic hit);
      return (hit && (v != '1)) ? v + rfc_pkg::STAT_W'(1) : v;
   endfunction

   always_comb begin
      enq_ok_in    = sat_inc(enq_ok_ff, evt.enq_ok);
      enq_full_in  = sat_inc(enq_full_ff, evt.enq_full);
      deq_ok_in    = sat_inc(deq_ok_ff, evt.deq_ok);
      deq_empty_in = sat_inc(deq_empty_ff, evt.deq_empty);
   end

   always_ff @(posedge clock) begin
      if (reset || evt.clear) begin
         enq_ok_ff    <= '0;
         enq_full_ff  <= '0;
         deq_ok_ff    <= '0;
         deq_empty_ff <= '0;
      end else begin
         enq_ok_ff    <= enq_ok_in;
         enq_full_ff  <= enq_full_in;
         deq_ok_ff    <= deq_ok_in;
         deq_empty_ff <= deq_empty_in;
      end
   end

   assign enq_ok_cnt    = enq_ok_ff;
   assign enq_full_cnt  = enq_full_ff;
   assign deq_ok_cnt    = deq_ok_ff;
   assign deq_empty_cnt = deq_empty_ff;

endmodule

// ----- sv/rfc_checker.sv -----
`include "assert_macros.svh"

module rfc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_status,
   input logic [rfc_pkg::DATA_W-1:0]    rsp_data_out,
   input logic                          rsp_is_empty,
   input logic                          rsp_is_full,
   input logic [rfc_pkg::OCC_W-1:0]     rsp_occupancy
);

   // The block works on one item at a time.
   `AST_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
             rsp_valid && $stable(rsp_data_out) && $stable(rsp_occupancy))

   `AST_SAME(a_empty_occ, clock, reset, rsp_valid && rsp_is_empty,
             (rsp_occupancy == '0) && !rsp_is_full)

   // Only a successful dequeue returns data.
   `AST_SAME(a_data_ok, clock, reset, rsp_valid && (rsp_data_out != '0),
             rsp_status == rfc_pkg::STATUS_DONE)

endmodule

bind ring_fifo_with_counters rfc_checker u_rfc_checker (.*);

// ----- tb/ring_fifo_with_counters_test.sv -----
`timescale 1ns / 100ps

module ring_fifo_with_counters_test;

   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic                       status;
      logic [rfc_pkg::DATA_W-1:0] data_out;
      logic                       is_empty;
      logic                       is_full;
      logic [rfc_pkg::OCC_W-1:0]  occupancy;
      logic [rfc_pkg::STAT_W-1:0] enq_count;
      logic [rfc_pkg::STAT_W-1:0] enq_full_count;
      logic [rfc_pkg::STAT_W-1:0] deq_count;
      logic [rfc_pkg::STAT_W-1:0] deq_empty_count;
   } fifo_result_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_wr_en;
   logic [rfc_pkg::CAP_W-1:0]    csr_wr_data;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_op;
   logic [rfc_pkg::DATA_W-1:0]   req_data_in;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_status;
   logic [rfc_pkg::DATA_W-1:0]   rsp_data_out;
   logic                         rsp_is_empty;
   logic                         rsp_is_full;
   logic [rfc_pkg::OCC_W-1:0]    rsp_occupancy;
   logic [rfc_pkg::STAT_W-1:0]   rsp_enqueue_count;
   logic [rfc_pkg::STAT_W-1:0]   rsp_enqueue_full_count;
   logic [rfc_pkg::STAT_W-1:0]   rsp_dequeue_count;
   logic [rfc_pkg::STAT_W-1:0]   rsp_dequeue_empty_count;

   fifo_result_type              expected_results[$];
   int                           mismatch_count = 0;
   bit                           pace_gaps = 1'b1;

   logic [rfc_pkg::CAP_W-1:0]    shadow_cap = rfc_pkg::CAP_RESET;
   logic [rfc_pkg::DATA_W-1:0]   shadow_mem [rfc_pkg::DEPTH];
   int                           shadow_wr_ptr = 0;
   int                           shadow_rd_ptr = 0;
   int                           shadow_fill = 0;
   logic [rfc_pkg::STAT_W-1:0]   shadow_enq_ok = '0;
   logic [rfc_pkg::STAT_W-1:0]   shadow_enq_full = '0;
   logic [rfc_pkg::STAT_W-1:0]   shadow_deq_ok = '0;
   logic [rfc_pkg::STAT_W-1:0]   shadow_deq_empty = '0;

   ring_fifo_with_counters u_top (
      .clock                   (clock),
      .reset                   (reset),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_op                  (req_op),
      .req_data_in             (req_data_in),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_data_out            (rsp_data_out),
      .rsp_is_empty            (rsp_is_empty),
      .rsp_is_full             (rsp_is_full),
      .rsp_occupancy           (rsp_occupancy),
      .rsp_enqueue_count       (rsp_enqueue_count),
      .rsp_enqueue_full_count  (rsp_enqueue_full_count),
      .rsp_dequeue_count       (rsp_dequeue_count),
      .rsp_dequeue_empty_count (rsp_dequeue_empty_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [rfc_pkg::STAT_W-1:0] saturating_bump(
      input logic [rfc_pkg::STAT_W-1:0] count);
      return (count == '1) ? count : count + rfc_pkg::STAT_W'(1);
   endfunction

   function automatic fifo_result_type apply_fifo_op(input logic op,
                                                     input logic [rfc_pkg::DATA_W-1:0] din);
      fifo_result_type res;
      int              cap;
      if (shadow_cap == '0) begin
         cap = 1;
      end else if (int'(shadow_cap) > rfc_pkg::DEPTH) begin
         cap = rfc_pkg::DEPTH;
      end else begin
         cap = int'(shadow_cap);
      end
      res = '0;
      res.status = rfc_pkg::STATUS_DONE;
      if (op == rfc_pkg::OP_ENQ) begin
         if (shadow_fill >= cap) begin
            res.status = rfc_pkg::STATUS_REJECT;
            shadow_enq_full = saturating_bump(shadow_enq_full);
         end else begin
            if (shadow_wr_ptr >= cap) begin
               shadow_wr_ptr = 0;
            end
            shadow_mem[shadow_wr_ptr] = din;
            shadow_wr_ptr = (shadow_wr_ptr + 1 >= cap) ? 0 : shadow_wr_ptr + 1;
            shadow_fill++;
            shadow_enq_ok = saturating_bump(shadow_enq_ok);
         end
      end else begin
         if (shadow_fill == 0) begin
            res.status = rfc_pkg::STATUS_REJECT;
            shadow_deq_empty = saturating_bump(shadow_deq_empty);
         end else begin
            if (shadow_rd_ptr >= cap) begin
               shadow_rd_ptr = 0;
            end
            res.data_out = shadow_mem[shadow_rd_ptr];
            shadow_rd_ptr = (shadow_rd_ptr + 1 >= cap) ? 0 : shadow_rd_ptr + 1;
            shadow_fill--;
            shadow_deq_ok = saturating_bump(shadow_deq_ok);
         end
      end
      res.is_empty        = (shadow_fill == 0);
      res.is_full         = (shadow_fill == cap);
      res.occupancy       = rfc_pkg::OCC_W'(shadow_fill);
      res.enq_count       = shadow_enq_ok;
      res.enq_full_count  = shadow_enq_full;
      res.deq_count       = shadow_deq_ok;
      res.deq_empty_count = shadow_deq_empty;
      return res;
   endfunction

   function automatic logic [rfc_pkg::DATA_W-1:0] random_data();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name,
                                input logic [rfc_pkg::STAT_W-1:0] got,
                                input logic [rfc_pkg::STAT_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   task automatic send_item(input logic op, input logic [rfc_pkg::DATA_W-1:0] din);
      int gap;
      gap = pace_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_data_in <= din;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writing the capacity empties the queue and clears every counter.
   task automatic write_capacity(input logic [rfc_pkg::CAP_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      shadow_cap       = value;
      shadow_wr_ptr    = 0;
      shadow_rd_ptr    = 0;
      shadow_fill      = 0;
      shadow_enq_ok    = '0;
      shadow_enq_full  = '0;
      shadow_deq_ok    = '0;
      shadow_deq_empty = '0;
   endtask

   task automatic test_reset_state();
      send_item(rfc_pkg::OP_DEQ, '1);
      send_item(rfc_pkg::OP_ENQ, 32'h0000_0000);
      send_item(rfc_pkg::OP_ENQ, 32'hFFFF_FFFF);
      send_item(rfc_pkg::OP_ENQ, 32'h5555_5555);
      send_item(rfc_pkg::OP_ENQ, 32'hAAAA_AAAA);
      repeat (4) send_item(rfc_pkg::OP_DEQ, random_data());
      send_item(rfc_pkg::OP_DEQ, '0);
      wait_quiet();
   endtask

   // A capacity of zero behaves as a single entry.
   task automatic test_capacity_floor();
      write_capacity('0);
      send_item(rfc_pkg::OP_ENQ, 32'h1234_5678);
      send_item(rfc_pkg::OP_ENQ, 32'h8765_4321);
      send_item(rfc_pkg::OP_DEQ, '0);
      send_item(rfc_pkg::OP_DEQ, '0);
      wait_quiet();
   endtask

   task automatic test_wrap_small();
      write_capacity(rfc_pkg::CAP_W'(3));
      repeat (3) send_item(rfc_pkg::OP_ENQ, random_data());
      send_item(rfc_pkg::OP_ENQ, random_data());
      send_item(rfc_pkg::OP_DEQ, random_data());
      send_item(rfc_pkg::OP_ENQ, random_data());
      repeat (3) send_item(rfc_pkg::OP_DEQ, random_data());
      send_item(rfc_pkg::OP_DEQ, random_data());
      wait_quiet();
   endtask

   task automatic test_random_traffic();
      logic [rfc_pkg::CAP_W-1:0] caps [9] = '{5'd16, 5'd1, 5'd2, 5'd7, 5'd31,
                                              5'd17, 5'd0, 5'd5, 5'd16};
      int                        k;
      int                        i;
      int                        enq_pct;
      caps[8] = rfc_pkg::CAP_W'($urandom_range(1, rfc_pkg::DEPTH));
      enq_pct = 50;
      for (k = 0; k < 9; k++) begin
         pace_gaps = (k % 4 != 3);
         write_capacity(caps[k]);
         for (i = 0; i < 125; i++) begin
            if (i % 16 == 0) begin
               enq_pct = $urandom_range(15, 85);
            end
            send_item(($urandom_range(1, 100) <= enq_pct) ? rfc_pkg::OP_ENQ
                                                          : rfc_pkg::OP_DEQ,
                      random_data());
         end
         wait_quiet();
      end
      pace_gaps = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         expected_results.push_back(apply_fifo_op(req_op, req_data_in));
      end
   end

   always @(posedge clock) begin
      fifo_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = expected_results.pop_front();
            compare_field("status", rfc_pkg::STAT_W'(rsp_status),
                          rfc_pkg::STAT_W'(want.status));
            compare_field("data_out", rfc_pkg::STAT_W'(rsp_data_out),
                          rfc_pkg::STAT_W'(want.data_out));
            compare_field("is_empty", rfc_pkg::STAT_W'(rsp_is_empty),
                          rfc_pkg::STAT_W'(want.is_empty));
            compare_field("is_full", rfc_pkg::STAT_W'(rsp_is_full),
                          rfc_pkg::STAT_W'(want.is_full));
            compare_field("occupancy", rfc_pkg::STAT_W'(rsp_occupancy),
                          rfc_pkg::STAT_W'(want.occupancy));
            compare_field("enqueue_count", rsp_enqueue_count, want.enq_count);
            compare_field("enqueue_full_count", rsp_enqueue_full_count,
                          want.enq_full_count);
            compare_field("dequeue_count", rsp_dequeue_count, want.deq_count);
            compare_field("dequeue_empty_count", rsp_dequeue_empty_count,
                          want.deq_empty_count);
         end
      end
   end

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = pace_gaps ? $urandom_range(0, 5) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_valid   <= 1'b0;
      req_op      <= rfc_pkg::OP_ENQ;
      req_data_in <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_capacity_floor();
      test_wrap_small();
      test_random_traffic();
      wait_quiet();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- ring_fifo_with_counters.f -----
+incdir+sv
sv/rfc_pkg.sv
sv/rfc_ram.sv
sv/rfc_stats.sv
sv/ring_fifo_with_counters.sv
sv/rfc_checker.sv
tb/ring_fifo_with_counters_test.sv
